// File: sv/pdfaf_pkg.sv
// Shared types and constants for the paced DAC ring / ADC framer.
// Holds item and result structs, configuration register codes and reset values.
// No dependencies.
package pdfaf_pkg;

	// Configuration port sizes
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	// Field widths
	localparam int CODE_W   = 16;
	localparam int TIME_W   = 32;
	localparam int ADC_W    = 12;
	localparam int SPF_W    = 10;
	localparam int RATE_W   = 10;
	localparam int PERIOD_W = 16;
	localparam int INTV_W   = 10;

	// Compare scaling: code is treated as a 12-bit fraction of the period
	localparam int SCALE_SHIFT = 12;

	// Reset and default values
	localparam logic [CODE_W-1:0]   CODE_RESET       = 16'd2048;
	localparam logic [ADC_W-1:0]    ADC_RESET        = 12'd2048;
	localparam logic [SPF_W-1:0]    SPF_RESET        = 10'd10;
	localparam logic [RATE_W-1:0]   RATE_RESET       = 10'd500;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET     = 16'hFFFF;
	localparam logic [INTV_W-1:0]   MS_PER_S         = 10'd1000;
	localparam logic [INTV_W-1:0]   INTERVAL_NO_RATE = 10'd10;
	localparam logic [INTV_W-1:0]   INTERVAL_RESET   = MS_PER_S / RATE_RESET;

	// Configuration register codes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STREAM_ENABLE     = 2'd0,
		CFG_SAMPLES_PER_FRAME = 2'd1,
		CFG_SAMPLE_RATE       = 2'd2,
		CFG_PWM_PERIOD        = 2'd3
	} cfg_reg_t;

	// Item operation codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_TIME = 1'b1;

	// Input item
	typedef struct packed {
		logic              op;
		logic [CODE_W-1:0] dac_code;
		logic [TIME_W-1:0] now_ms;
		logic [ADC_W-1:0]  adc_reading;
		logic              adc_ok;
	} item_t;

	// Result item
	typedef struct packed {
		logic [PERIOD_W-1:0] pwm_compare;
		logic [ADC_W-1:0]    adc_sample;
		logic                frame_end;
	} result_t;

endpackage

// File: sv/paced_dac_fifo_adc_framer_top.sv
// Top level of the paced DAC ring buffer with ADC frame capture.
// Holds the ring memory, pacing logic, interval divider and compare scaling.
// Depends on pdfaf_pkg.
//
//  port group   role     payload      notes
//  item_*       sink     item_t       push (op 0) or time step (op 1)
//  res_*        source   result_t     one result per sample point
//  cfg_*        write    16-bit data  registers 0..3, no read-back
//
// One item is taken every cycle while item_stall is low; its result passes the input, scale and output registers.
// A nonzero sample-rate write starts a shift-subtract divide that works out
// the interval; item_stall stays high until it completes.
// The ring is read every cycle at the next head address into a registered port.
// arst_n clears pointers, pacing state and registers; the ring is not cleared.
// res_stall backs up through the output, scale and input registers in turn.
module paced_dac_fifo_adc_framer_top #(
	parameter int RING_DEPTH = 8192,
	parameter int MAX_FRAME  = 1000
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  pdfaf_pkg::item_t                     item,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output pdfaf_pkg::result_t                   res,
	input  logic                                 cfg_we,
	input  logic [pdfaf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pdfaf_pkg::CFG_W-1:0]          cfg_wdata
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam int FW = $clog2(MAX_FRAME + 1);
	localparam logic [AW-1:0] PTR_LAST = AW'(RING_DEPTH - 1);
	localparam logic [31:0] MAX_FRAME_U = 32'(MAX_FRAME);
	localparam int DW = pdfaf_pkg::INTV_W;
	localparam logic [3:0] DIV_STEPS = 4'(DW);
	localparam int PROD_W = pdfaf_pkg::CODE_W + pdfaf_pkg::PERIOD_W + 1;
	localparam int SCL_W = PROD_W - pdfaf_pkg::SCALE_SHIFT;

	// Configuration registers
	logic                              en_q;
	logic [pdfaf_pkg::SPF_W-1:0]       spf_q;
	logic [pdfaf_pkg::PERIOD_W-1:0]    period_q;
	logic [pdfaf_pkg::INTV_W-1:0]      interval_q;

	// Interval divider
	logic                              div_busy_q;
	logic [3:0]                        div_cnt_q;
	logic [DW-1:0]                     div_num_q;
	logic [DW-1:0]                     div_rem_q;
	logic [DW-1:0]                     div_quo_q;
	logic [DW-1:0]                     div_den_q;
	logic [DW:0]                       div_rem_sh;
	logic                              div_ge;
	logic [DW:0]                       div_rem_sub;

	// Ring state
	logic [pdfaf_pkg::CODE_W-1:0]      ring_mem [RING_DEPTH];
	logic [pdfaf_pkg::CODE_W-1:0]      ring_rdata_q;
	logic                              byp_q;
	logic [pdfaf_pkg::CODE_W-1:0]      byp_data_q;
	logic [pdfaf_pkg::CODE_W-1:0]      head;
	logic [AW-1:0]                     wp_q, rp_q, wp_d, rp_d, wp_inc, rp_inc;
	logic                              ring_we;

	// Pacing and frame state
	logic [pdfaf_pkg::TIME_W-1:0]      last_q;
	logic                              started_q;
	logic [FW-1:0]                     fi_q;
	logic [pdfaf_pkg::CODE_W-1:0]      held_code_q;
	logic [pdfaf_pkg::ADC_W-1:0]       held_adc_q;

	// Pipeline
	logic                              s1_v_q;
	pdfaf_pkg::item_t                  item_s1;
	logic                              s2_v_q;
	logic [pdfaf_pkg::CODE_W-1:0]      code_s2;
	logic [pdfaf_pkg::ADC_W-1:0]       adc_s2;
	logic                              end_s2;
	logic                              out_v_q;
	pdfaf_pkg::result_t                res_q;
	logic                              out_ready, s2_ready, s1_ready, s1_go, item_acc;

	// Step logic
	logic                              cfg_clear;
	logic                              is_push, is_time;
	logic [pdfaf_pkg::TIME_W-1:0]      base_time, elapsed, next_pace;
	logic [pdfaf_pkg::TIME_W-1:0]      intv_ext, intv2_ext;
	logic                              sample, late, do_pop;
	logic [pdfaf_pkg::CODE_W-1:0]      code_new;
	logic [pdfaf_pkg::ADC_W-1:0]       adc_new;
	logic [31:0]                       spf_ext, spf_lim;
	logic [FW-1:0]                     spf_eff;
	logic [FW:0]                       fi_inc;
	logic                              frame_end;
	logic [FW-1:0]                     fi_next;
	logic [PROD_W-1:0]                 prod;
	logic [SCL_W-1:0]                  scaled;
	logic [pdfaf_pkg::PERIOD_W-1:0]    cmp;

	// Handshake chain
	assign out_ready  = !out_v_q || !res_stall;
	assign s2_ready   = !s2_v_q || out_ready;
	assign s1_ready   = !s1_v_q || s2_ready;
	assign s1_go      = s1_v_q && s2_ready;
	assign item_stall = div_busy_q || !s1_ready;
	assign item_acc   = item_valid && !item_stall;

	assign cfg_clear = cfg_we && (pdfaf_pkg::cfg_reg_t'(cfg_index) == pdfaf_pkg::CFG_STREAM_ENABLE)
		&& cfg_wdata[0];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q     <= 1'b0;
			spf_q    <= pdfaf_pkg::SPF_RESET;
			period_q <= pdfaf_pkg::PERIOD_RESET;
		end else if (cfg_we) begin
			case (pdfaf_pkg::cfg_reg_t'(cfg_index))
				pdfaf_pkg::CFG_STREAM_ENABLE:     en_q     <= cfg_wdata[0];
				pdfaf_pkg::CFG_SAMPLES_PER_FRAME: spf_q    <= cfg_wdata[pdfaf_pkg::SPF_W-1:0];
				pdfaf_pkg::CFG_PWM_PERIOD:        period_q <= cfg_wdata[pdfaf_pkg::PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// Divider step: one quotient bit of 1000 / rate per cycle
	assign div_rem_sh  = {div_rem_q, div_num_q[DW-1]};
	assign div_ge      = div_rem_sh >= {1'b0, div_den_q};
	assign div_rem_sub = div_ge ? (div_rem_sh - {1'b0, div_den_q}) : div_rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
			interval_q <= pdfaf_pkg::INTERVAL_RESET;
		end else if (cfg_we && (pdfaf_pkg::cfg_reg_t'(cfg_index) == pdfaf_pkg::CFG_SAMPLE_RATE)) begin
			if (cfg_wdata[pdfaf_pkg::RATE_W-1:0] == '0) begin
				div_busy_q <= 1'b0;
				interval_q <= pdfaf_pkg::INTERVAL_NO_RATE;
			end else begin
				div_busy_q <= 1'b1;
				div_cnt_q  <= DIV_STEPS;
			end
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q - 4'd1;
			if (div_cnt_q == 4'd1) begin
				div_busy_q <= 1'b0;
				interval_q <= {div_quo_q[DW-2:0], div_ge};
			end
		end
	end

	// Divider datapath
	always_ff @(posedge clk) begin
		if (cfg_we && (pdfaf_pkg::cfg_reg_t'(cfg_index) == pdfaf_pkg::CFG_SAMPLE_RATE)) begin
			div_num_q <= pdfaf_pkg::MS_PER_S;
			div_rem_q <= '0;
			div_quo_q <= '0;
			div_den_q <= cfg_wdata[pdfaf_pkg::RATE_W-1:0];
		end else if (div_busy_q) begin
			div_num_q <= {div_num_q[DW-2:0], 1'b0};
			div_rem_q <= div_rem_sub[DW-1:0];
			div_quo_q <= {div_quo_q[DW-2:0], div_ge};
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (s1_ready) begin
			s1_v_q <= item_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			item_s1 <= item;
		end
	end

	// Pacing decision for the item in the input register
	assign is_push   = s1_go && (item_s1.op == pdfaf_pkg::OP_PUSH);
	assign is_time   = s1_go && (item_s1.op == pdfaf_pkg::OP_TIME) && en_q;
	assign base_time = started_q ? last_q : item_s1.now_ms;
	assign elapsed   = item_s1.now_ms - base_time;
	assign intv_ext  = 32'(interval_q);
	assign intv2_ext = {intv_ext[30:0], 1'b0};
	assign sample    = is_time && (elapsed >= intv_ext);
	assign late      = elapsed > intv2_ext;
	assign next_pace = late ? item_s1.now_ms : (base_time + intv_ext);

	// Ring pointers
	assign wp_inc  = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
	assign rp_inc  = (rp_q == PTR_LAST) ? '0 : rp_q + 1'b1;
	assign ring_we = is_push;
	assign do_pop  = sample && (rp_q != wp_q);

	always_comb begin
		wp_d = wp_q;
		rp_d = rp_q;
		if (cfg_clear) begin
			wp_d = '0;
			rp_d = '0;
		end else if (ring_we) begin
			wp_d = wp_inc;
			if (wp_inc == rp_q) begin
				rp_d = rp_inc;
			end
		end else if (do_pop) begin
			rp_d = rp_inc;
		end
	end

	// Ring memory: write at the tail, read the next head every cycle
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[wp_q] <= item_s1.dac_code;
		end
	end

	always_ff @(posedge clk) begin
		ring_rdata_q <= ring_mem[rp_d];
		byp_data_q   <= item_s1.dac_code;
	end

	// Forward a code written to the address being read in the same cycle
	assign head = byp_q ? byp_data_q : ring_rdata_q;

	// Frame counting
	assign spf_ext = 32'(spf_q);
	assign spf_lim = (spf_ext > MAX_FRAME_U) ? MAX_FRAME_U : spf_ext;
	assign spf_eff = spf_lim[FW-1:0];
	assign fi_inc  = {1'b0, fi_q} + 1'b1;
	assign frame_end = fi_inc >= {1'b0, spf_eff};
	assign fi_next = frame_end ? '0 : fi_inc[FW-1:0];

	assign code_new = do_pop ? head : held_code_q;
	assign adc_new  = item_s1.adc_ok ? item_s1.adc_reading : held_adc_q;

	// Block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			rp_q        <= '0;
			byp_q       <= 1'b0;
			last_q      <= '0;
			started_q   <= 1'b0;
			fi_q        <= '0;
			held_code_q <= pdfaf_pkg::CODE_RESET;
			held_adc_q  <= pdfaf_pkg::ADC_RESET;
		end else begin
			wp_q  <= wp_d;
			rp_q  <= rp_d;
			byp_q <= ring_we && (wp_q == rp_d);
			if (cfg_clear) begin
				last_q    <= '0;
				started_q <= 1'b0;
				fi_q      <= '0;
			end else if (is_time) begin
				started_q <= 1'b1;
				last_q    <= sample ? next_pace : base_time;
				if (sample) begin
					fi_q        <= fi_next;
					held_code_q <= code_new;
					held_adc_q  <= adc_new;
				end
			end
		end
	end

	// Scale stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_q <= 1'b0;
		end else if (s2_ready) begin
			s2_v_q <= sample;
		end
	end

	always_ff @(posedge clk) begin
		if (sample) begin
			code_s2 <= code_new;
			adc_s2  <= adc_new;
			end_s2  <= frame_end;
		end
	end

	// Compare scaling: (code * (period + 1)) >> 12, capped at period
	assign prod   = PROD_W'(code_s2) * PROD_W'({1'b0, period_q} + 17'd1);
	assign scaled = prod[PROD_W-1:pdfaf_pkg::SCALE_SHIFT];
	assign cmp    = (scaled > SCL_W'(period_q)) ? period_q : scaled[pdfaf_pkg::PERIOD_W-1:0];

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_ready) begin
			out_v_q <= s2_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && s2_v_q) begin
			res_q.pwm_compare <= cmp;
			res_q.adc_sample  <= adc_s2;
			res_q.frame_end   <= end_s2;
		end
	end

	assign res_valid = out_v_q;
	assign res       = res_q;

endmodule

// File: sv/pdfaf_checker.sv
// Port-level checks for the paced DAC ring / ADC framer.
// Shadows the configuration writes it needs and binds to the top level.
// Depends on pdfaf_pkg and paced_dac_fifo_adc_framer_top.
module pdfaf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            item_valid,
	input logic                            item_stall,
	input pdfaf_pkg::item_t                item,
	input logic                            res_valid,
	input logic                            res_stall,
	input pdfaf_pkg::result_t              res,
	input logic                            cfg_we,
	input logic [pdfaf_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [pdfaf_pkg::CFG_W-1:0]     cfg_wdata
);

	logic                           en_q;
	logic [pdfaf_pkg::SPF_W-1:0]    spf_q;
	logic [pdfaf_pkg::PERIOD_W-1:0] period_q;

	// Shadow copies of the registers the checks depend on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q     <= 1'b0;
			spf_q    <= pdfaf_pkg::SPF_RESET;
			period_q <= pdfaf_pkg::PERIOD_RESET;
		end else if (cfg_we) begin
			case (pdfaf_pkg::cfg_reg_t'(cfg_index))
				pdfaf_pkg::CFG_STREAM_ENABLE:     en_q     <= cfg_wdata[0];
				pdfaf_pkg::CFG_SAMPLES_PER_FRAME: spf_q    <= cfg_wdata[pdfaf_pkg::SPF_W-1:0];
				pdfaf_pkg::CFG_PWM_PERIOD:        period_q <= cfg_wdata[pdfaf_pkg::PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// A stalled input item stays put
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("input item changed or withdrawn while stalled");

	// A stalled result stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed or dropped while stalled");

	// Scaled compare never exceeds the period
	a_cmp_cap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.pwm_compare <= period_q)
		else $error("pwm_compare above pwm_period");

	// With a frame of zero or one sample, every result ends a frame
	a_short_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (spf_q <= 10'd1) |-> res.frame_end)
		else $error("frame_end missing for single-sample frame");

	// No results while pacing is off
	a_no_res_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		!en_q |-> !res_valid)
		else $error("result produced while streaming disabled");

endmodule

bind paced_dac_fifo_adc_framer_top pdfaf_checker u_pdfaf_checker (.*);

// File: tb/sv/tb.sv
// Self-checking testbench for paced_dac_fifo_adc_framer_top: ring pushes, paced pops,
// compare scaling and ADC frame marking, checked against an in-bench predictor.
// Depends on pdfaf_pkg and the top level; needs no files or arguments.
`timescale 1ns / 1ps

module tb;
	import pdfaf_pkg::*;

	localparam int RING_SLOTS    = 8192;
	localparam int MAX_FRAME_LEN = 1000;
	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT   = 600000;

	// Predictor of the sample points and store of the results still due
	class pacer_scoreboard;
		bit [CODE_W-1:0]                 ring [RING_SLOTS];
		bit [$clog2(RING_SLOTS)-1:0]     wr_ptr;
		bit [$clog2(RING_SLOTS)-1:0]     rd_ptr;
		bit [TIME_W-1:0]                 last_pace;
		bit                              paced;
		int unsigned                     frame_pos;
		bit [CODE_W-1:0]                 held_code;
		bit [ADC_W-1:0]                  held_adc;
		bit                              enabled;
		bit [SPF_W-1:0]                  frame_len;
		bit [RATE_W-1:0]                 rate;
		bit [PERIOD_W-1:0]               period;
		result_t                         due_samples [$];
		int unsigned                     mismatches, samples, frame_ends, pushes, steps;

		function new();
			held_code = CODE_RESET;
			held_adc  = ADC_RESET;
			frame_len = SPF_RESET;
			rate      = RATE_RESET;
			period    = PERIOD_RESET;
		endfunction

		function int unsigned interval();
			return (rate != 0) ? int'(MS_PER_S) / int'(rate) : int'(INTERVAL_NO_RATE);
		endfunction

		function int unsigned pending();
			return due_samples.size();
		endfunction

		function void write_reg(cfg_reg_t idx, bit [CFG_W-1:0] val);
			case (idx)
				CFG_STREAM_ENABLE: begin
					enabled = val[0];
					// enabling restarts the ring and the pacing
					if (enabled) begin
						wr_ptr    = '0;
						rd_ptr    = '0;
						last_pace = '0;
						paced     = 1'b0;
						frame_pos = 0;
					end
				end
				CFG_SAMPLES_PER_FRAME: frame_len = val[SPF_W-1:0];
				CFG_SAMPLE_RATE:       rate      = val[RATE_W-1:0];
				CFG_PWM_PERIOD:        period    = val[PERIOD_W-1:0];
				default: ;
			endcase
		endfunction

		// Note one accepted item and queue the sample it causes, if any
		function void take_item(item_t it);
			bit [TIME_W-1:0]   gap;
			int unsigned       iv, spf;
			longint unsigned   scaled;
			result_t           s;
			if (it.op == OP_PUSH) begin
				pushes++;
				ring[wr_ptr] = it.dac_code;
				wr_ptr++;
				// full ring: oldest code is dropped
				if (wr_ptr == rd_ptr)
					rd_ptr++;
				return;
			end
			steps++;
			if (!enabled)
				return;
			iv = interval();
			if (!paced) begin
				last_pace = it.now_ms;
				paced     = 1'b1;
			end
			gap = it.now_ms - last_pace;
			if (gap < iv)
				return;
			if (gap > 2 * iv)
				last_pace = it.now_ms;
			else
				last_pace += iv;
			// empty ring keeps the last code
			if (rd_ptr != wr_ptr) begin
				held_code = ring[rd_ptr];
				rd_ptr++;
			end
			scaled = (longint'(held_code) * (longint'(period) + 1)) >> SCALE_SHIFT;
			s.pwm_compare = (scaled > period) ? period : scaled[PERIOD_W-1:0];
			if (it.adc_ok)
				held_adc = it.adc_reading;
			s.adc_sample = held_adc;
			spf = (frame_len > MAX_FRAME_LEN) ? MAX_FRAME_LEN : frame_len;
			frame_pos++;
			s.frame_end = 1'b0;
			if (frame_pos >= spf) begin
				s.frame_end = 1'b1;
				frame_pos   = 0;
			end
			due_samples.push_back(s);
		endfunction

		// Compare one accepted result with the oldest one due
		function void match_sample(result_t got);
			result_t exp;
			samples++;
			if (due_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] unexpected result: cmp=%0d adc=%0d end=%0b",
						$time, got.pwm_compare, got.adc_sample, got.frame_end);
				return;
			end
			exp = due_samples.pop_front();
			if (exp.frame_end)
				frame_ends++;
			if (got.pwm_compare !== exp.pwm_compare || got.adc_sample !== exp.adc_sample ||
			    got.frame_end !== exp.frame_end) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("[%0t] sample %0d: exp cmp=%0d adc=%0d end=%0b",
						$time, samples, exp.pwm_compare, exp.adc_sample, exp.frame_end);
					$display("    got cmp=%0d adc=%0d end=%0b",
						got.pwm_compare, got.adc_sample, got.frame_end);
				end
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_stall;
	item_t                 item;
	logic                  res_valid;
	logic                  res_stall;
	result_t               res;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_wdata;

	pacer_scoreboard       board;
	int unsigned           send_idle, stall_pct, push_pct;
	int unsigned           clock_count;
	bit [TIME_W-1:0]       cursor;

	paced_dac_fifo_adc_framer_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Run limit
	always @(posedge clk) begin
		clock_count++;
		if (clock_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver: random stall, checks on accepted results
	always @(negedge clk) begin
		res_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0)
			board.match_sample(res);
	end

	function automatic item_t mk_push(bit [CODE_W-1:0] code);
		item_t it;
		it.op          = OP_PUSH;
		it.dac_code    = code;
		it.now_ms      = $urandom;
		it.adc_reading = ADC_W'($urandom);
		it.adc_ok      = 1'($urandom);
		return it;
	endfunction

	function automatic item_t mk_step(bit [TIME_W-1:0] now, bit [ADC_W-1:0] adc, bit ok);
		item_t it;
		it.op          = OP_TIME;
		it.dac_code    = CODE_W'($urandom);
		it.now_ms      = now;
		it.adc_reading = adc;
		it.adc_ok      = ok;
		return it;
	endfunction

	// Random pushes and mostly well-paced time steps, with early, late and wild jumps mixed in
	function automatic item_t random_item();
		int unsigned iv, r;
		iv = board.interval();
		if ($urandom_range(99) < push_pct)
			return mk_push(CODE_W'($urandom));
		r = $urandom_range(99);
		if (r < 4)
			cursor = $urandom;
		else if (r < 14)
			cursor += 2 * iv + $urandom_range(1, 40);
		else if (r < 24)
			cursor += $urandom_range(0, iv);
		else if (r < 34)
			cursor += 2 * iv;
		else
			cursor += iv;
		return mk_step(cursor, ADC_W'($urandom), 1'($urandom));
	endfunction

	// Offer one item, called and returning at a falling edge
	task automatic send_item(item_t it);
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall !== 1'b0)
			@(posedge clk);
		board.take_item(it);
		@(negedge clk);
	endtask

	// Hold off the sender until every due sample has arrived
	task automatic drain();
		item_valid <= 1'b0;
		do
			@(negedge clk);
		while (board.pending() != 0);
	endtask

	// Drain, then let pushes still in the pipe finish before a register write
	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		board.write_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_phase(int n, int unsigned sidle, int unsigned rstall, bit hold_mid);
		send_idle = sidle;
		stall_pct = rstall;
		push_pct  = $urandom_range(20, 60);
		cursor    = $urandom;
		for (int k = 0; k < n; k++) begin
			if (hold_mid && k == n / 2)
				drain();
			send_item(random_item());
		end
		settle();
	endtask

	initial begin
		board      = new();
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_wdata  = '0;
		send_idle  = 0;
		stall_pct  = 0;
		push_pct   = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Disabled: time step does nothing, push is still stored
		send_item(mk_step(32'hFFFF_FFFF, 12'hFFF, 1'b1));
		send_item(mk_push(16'hFFFF));
		settle();

		// Zero interval, frame size zero, full period
		set_reg(CFG_STREAM_ENABLE, 16'd1);
		set_reg(CFG_SAMPLES_PER_FRAME, 16'd0);
		set_reg(CFG_SAMPLE_RATE, 16'd1023);
		set_reg(CFG_PWM_PERIOD, 16'hFFFF);
		send_item(mk_step(32'd0, 12'd0, 1'b0));
		send_item(mk_push(16'hFFFF));
		send_item(mk_push(16'h0000));
		send_item(mk_push(16'd4096));
		send_item(mk_push(16'd1));
		send_item(mk_step(32'd0, 12'hFFF, 1'b1));
		send_item(mk_step(32'd1, 12'h000, 1'b0));
		send_item(mk_step(32'd2, 12'h000, 1'b1));
		send_item(mk_step(32'd3, 12'h5A5, 1'b1));
		send_item(mk_step(32'd4, 12'hA5A, 1'b0));
		settle();

		// 10 ms default interval across the time wrap, late resync, zero period
		set_reg(CFG_SAMPLE_RATE, 16'd0);
		set_reg(CFG_SAMPLES_PER_FRAME, 16'd1000);
		set_reg(CFG_PWM_PERIOD, 16'd0);
		set_reg(CFG_STREAM_ENABLE, 16'd1);
		send_item(mk_step(32'hFFFF_FFFA, 12'd1, 1'b1));
		send_item(mk_step(32'hFFFF_FFFF, 12'd2, 1'b1));
		send_item(mk_step(32'd4, 12'd3, 1'b1));
		send_item(mk_step(32'd24, 12'd4, 1'b1));
		send_item(mk_step(32'd100, 12'd5, 1'b1));
		send_item(mk_step(32'd105, 12'd6, 1'b1));
		settle();

		// One ms interval, every sample ends a frame, period of one
		set_reg(CFG_SAMPLE_RATE, 16'd1000);
		set_reg(CFG_SAMPLES_PER_FRAME, 16'd1);
		set_reg(CFG_PWM_PERIOD, 16'd1);
		send_item(mk_push(16'hFFFF));
		send_item(mk_step(32'd106, 12'd7, 1'b1));
		send_item(mk_step(32'd107, 12'd8, 1'b0));
		settle();

		// Ring burst: codes pushed back to back, then popped until empty
		set_reg(CFG_STREAM_ENABLE, 16'd1);
		set_reg(CFG_SAMPLE_RATE, 16'd1023);
		set_reg(CFG_SAMPLES_PER_FRAME, 16'd3);
		set_reg(CFG_PWM_PERIOD, 16'($urandom));
		for (int k = 0; k < 24; k++)
			send_item(mk_push(CODE_W'($urandom)));
		for (int k = 0; k < 32; k++)
			send_item(mk_step(TIME_W'(k), ADC_W'($urandom), 1'($urandom)));
		settle();

		// Random phases under the different idling patterns
		set_reg(CFG_STREAM_ENABLE, 16'd1);
		set_reg(CFG_SAMPLES_PER_FRAME, 16'($urandom_range(1, 20)));
		set_reg(CFG_SAMPLE_RATE, 16'd1000);
		set_reg(CFG_PWM_PERIOD, 16'($urandom));
		run_phase(300, 0, 0, 1'b0);

		set_reg(CFG_SAMPLES_PER_FRAME, 16'd7);
		set_reg(CFG_SAMPLE_RATE, 16'($urandom_range(1, 1000)));
		set_reg(CFG_PWM_PERIOD, 16'hFFFF);
		run_phase(300, 63, 0, 1'b1);

		set_reg(CFG_STREAM_ENABLE, 16'd1);
		set_reg(CFG_SAMPLES_PER_FRAME, 16'd1023);
		set_reg(CFG_SAMPLE_RATE, 16'd1);
		set_reg(CFG_PWM_PERIOD, 16'($urandom));
		run_phase(300, 0, 63, 1'b0);

		set_reg(CFG_SAMPLES_PER_FRAME, 16'd0);
		set_reg(CFG_SAMPLE_RATE, 16'd0);
		set_reg(CFG_PWM_PERIOD, 16'($urandom_range(0, 4095)));
		run_phase(300, 14, 14, 1'b0);

		// Streaming off: pushes still land in the ring
		set_reg(CFG_STREAM_ENABLE, 16'd0);
		run_phase(80, 0, 0, 1'b0);

		set_reg(CFG_STREAM_ENABLE, 16'd1);
		set_reg(CFG_SAMPLES_PER_FRAME, 16'($urandom_range(0, 1023)));
		set_reg(CFG_SAMPLE_RATE, 16'($urandom_range(1, 50)));
		set_reg(CFG_PWM_PERIOD, 16'($urandom));
		run_phase(300, 63, 0, 1'b0);

		set_reg(CFG_SAMPLES_PER_FRAME, 16'($urandom_range(1, 30)));
		set_reg(CFG_SAMPLE_RATE, 16'($urandom_range(1001, 1023)));
		run_phase(120, 0, 63, 1'b0);

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("Run covered %0d pushes, %0d time steps, %0d samples and %0d frame ends",
			board.pushes, board.steps, board.samples, board.frame_ends);
		$display("under four idling patterns; %0d mismatches in %0d cycles.",
			board.mismatches, clock_count);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
